/* hdl/dfir_pkg.sv */
// ----------------------------------------------------------------------------
// dfir_pkg
// Shared types and constants of the decimating complex FIR core.
// ----------------------------------------------------------------------------
package dfir_pkg;

    localparam int MAX_TAPS     = 256;
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = SAMPLE_BITS - 1;
    localparam int TAP_IDX_BITS = $clog2(MAX_TAPS);
    localparam int CNT_BITS     = $clog2(MAX_TAPS + 1);
    localparam int PROD_BITS    = 2 * SAMPLE_BITS;
    localparam int ACC_BITS     = PROD_BITS + TAP_IDX_BITS + 1;

    // Fixed register field widths.
    localparam int TAP_COUNT_BITS  = 9;
    localparam int DECIMATION_BITS = 8;
    localparam int CFG_DATA_BITS   = 9;
    localparam int TAP_INDEX_BITS  = 8;

    localparam logic REG_TAP_COUNT  = 1'b0;
    localparam logic REG_DECIMATION = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic rotate;
        logic coef_we;
    } cell_ctl_t;

    typedef struct packed {
        logic start;
        logic prod_en;
    } mac_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          sat;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_TAIL,
        ST_DONE
    } state_t;

endpackage

/* hdl/dfir_if.sv */
// ----------------------------------------------------------------------------
// dfir_if
// Valid/ready stream interfaces for the input items and the result items.
// ----------------------------------------------------------------------------
interface dfir_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic [dfir_pkg::TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [dfir_pkg::SAMPLE_BITS-1:0] tap_re;
    logic signed [dfir_pkg::SAMPLE_BITS-1:0] tap_im;
    logic signed [dfir_pkg::SAMPLE_BITS-1:0] sample_re;
    logic signed [dfir_pkg::SAMPLE_BITS-1:0] sample_im;

    modport source (output valid, kind, tap_index, tap_re, tap_im, sample_re, sample_im,
                    input ready);
    modport sink   (input valid, kind, tap_index, tap_re, tap_im, sample_re, sample_im,
                    output ready);
endinterface

interface dfir_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dfir_pkg::SAMPLE_BITS-1:0] out_re;
    logic signed [dfir_pkg::SAMPLE_BITS-1:0] out_im;
    logic                                    saturated;

    modport source (output valid, out_re, out_im, saturated, input ready);
    modport sink   (input valid, out_re, out_im, saturated, output ready);
endinterface

/* hdl/dfir_cell.sv */
// ----------------------------------------------------------------------------
// dfir_cell
// One tap position: holds a history sample and a coefficient and passes
// the sample to its neighbor on shift and both on rotate.
// ----------------------------------------------------------------------------
module dfir_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dfir_pkg::cell_ctl_t ctl,
    input  dfir_pkg::cplx_t     tap_val,
    input  dfir_pkg::cplx_t     shift_in,
    input  dfir_pkg::cplx_t     rot_hist_in,
    input  dfir_pkg::cplx_t     rot_coef_in,
    output dfir_pkg::cplx_t     hist,
    output dfir_pkg::cplx_t     coef
);
    import dfir_pkg::*;

    cplx_t hist_reg, hist_next;
    cplx_t coef_reg, coef_next;

    always_comb
    begin
        hist_next = hist_reg;
        coef_next = coef_reg;
        if (ctl.clear)
        begin
            hist_next = '0;
        end
        else if (ctl.shift)
        begin
            hist_next = shift_in;
        end
        else if (ctl.rotate)
        begin
            hist_next = rot_hist_in;
            coef_next = rot_coef_in;
        end
        if (ctl.coef_we)
        begin
            coef_next = tap_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            coef_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            coef_reg <= coef_next;
        end
    end

    assign hist = hist_reg;
    assign coef = coef_reg;

endmodule

/* hdl/dfir_mac.sv */
// ----------------------------------------------------------------------------
// dfir_mac
// Complex multiply-accumulate at the head of the cell chain, with
// round-half-up and saturation of the final sum.
// ----------------------------------------------------------------------------
module dfir_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  dfir_pkg::mac_ctl_t ctl,
    input  dfir_pkg::cplx_t    h,
    input  dfir_pkg::cplx_t    x,
    output dfir_pkg::result_t  res
);
    import dfir_pkg::*;

    localparam logic signed [ACC_BITS-1:0] HALF_LSB = ACC_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX  = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN  = -(ACC_BITS'(1) <<< (SAMPLE_BITS - 1));

    logic signed [PROD_BITS-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                        prod_en_reg;
    logic signed [ACC_BITS-1:0]  acc_re_reg, acc_re_next;
    logic signed [ACC_BITS-1:0]  acc_im_reg, acc_im_next;
    logic                        sat_re, sat_im;

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            p_rr_reg <= h.re * x.re;
            p_ii_reg <= h.im * x.im;
            p_ri_reg <= h.re * x.im;
            p_ir_reg <= h.im * x.re;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_en_reg <= 1'b0;
        end
        else
        begin
            prod_en_reg <= ctl.prod_en;
        end
    end

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl.start)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (prod_en_reg)
        begin
            acc_re_next = acc_re_reg + ACC_BITS'(p_rr_reg) - ACC_BITS'(p_ii_reg);
            acc_im_next = acc_im_reg + ACC_BITS'(p_ri_reg) + ACC_BITS'(p_ir_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input  logic signed [ACC_BITS-1:0] acc,
        output logic                       clip
    );
        logic signed [ACC_BITS-1:0] r;
        r    = (acc + HALF_LSB) >>> FRAC_BITS;
        clip = 1'b0;
        if (r > SAT_MAX)
        begin
            r    = SAT_MAX;
            clip = 1'b1;
        end
        else if (r < SAT_MIN)
        begin
            r    = SAT_MIN;
            clip = 1'b1;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    always_comb
    begin
        res.re  = round_sat(acc_re_reg, sat_re);
        res.im  = round_sat(acc_im_reg, sat_im);
        res.sat = sat_re | sat_im;
    end

endmodule

/* hdl/decimating_complex_fir_core.sv */
// ----------------------------------------------------------------------------
// decimating_complex_fir_core
// Decimating complex FIR filter built as a ring of tap cells with one
// complex multiply-accumulate unit at the head of the ring.
// ----------------------------------------------------------------------------
// Tap writes and samples that produce no output leave the core idle.
// For a sample that produces an output, the ring is rotated once through
// the single multiply-accumulate unit (states ROT, TAIL, DONE). In DONE the
// result is loaded into the output register and the core returns to idle
// to take the next item, unless an earlier result still waits in the output
// register.
// Reset clears all taps, the history and the phase at once, and sets
// tap_count and decimation to 1.
// ----------------------------------------------------------------------------
module decimating_complex_fir_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dfir_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    dfir_in_if.sink                              item,
    dfir_out_if.source                           result
);
    import dfir_pkg::*;

    // Configuration registers and the decimation phase.
    logic [TAP_COUNT_BITS-1:0]  tap_count_reg, tap_count_next;
    logic [DECIMATION_BITS-1:0] decimation_reg, decimation_next;
    logic [DECIMATION_BITS-1:0] phase_reg, phase_next;

    // Sequencer.
    state_t                    state_reg, state_next;
    logic [TAP_IDX_BITS-1:0]   cnt_reg, cnt_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg;

    logic                      item_xfer;
    logic                      sample_xfer;
    logic                      tap_xfer;
    logic                      emit;
    logic                      clear_hist;
    logic                      rotate;
    logic                      out_load;
    logic [CNT_BITS-1:0]       ntaps;
    logic [DECIMATION_BITS-1:0] dec_eff;
    logic [DECIMATION_BITS:0]  phase_inc;

    cplx_t                     new_sample;
    cplx_t                     tap_val;
    cplx_t                     hist [MAX_TAPS];
    cplx_t                     coef [MAX_TAPS];
    mac_ctl_t                  mac_ctl;
    result_t                   mac_res;

    // ------------------------------------------------------------------------
    // Item handshake. Items are taken only while the ring is at rest, so
    // every cell sits at its own tap position during a shift or a tap write.
    // ------------------------------------------------------------------------
    assign item.ready  = (state_reg == ST_IDLE);
    assign item_xfer   = item.valid && item.ready;
    assign sample_xfer = item_xfer && (item.kind == KIND_SAMPLE);
    assign tap_xfer    = item_xfer && (item.kind == KIND_TAP);

    assign new_sample.re = item.sample_re;
    assign new_sample.im = item.sample_im;
    assign tap_val.re    = item.tap_re;
    assign tap_val.im    = item.tap_im;

    // Effective tap count and decimation: zero acts as one, and a tap count
    // above the ring length is clamped to it.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            ntaps = CNT_BITS'(1);
        end
        else if (CNT_BITS'(tap_count_reg) > CNT_BITS'(MAX_TAPS))
        begin
            ntaps = CNT_BITS'(MAX_TAPS);
        end
        else
        begin
            ntaps = CNT_BITS'(tap_count_reg);
        end
    end

    assign dec_eff   = (decimation_reg == '0) ? DECIMATION_BITS'(1) : decimation_reg;
    assign phase_inc = {1'b0, phase_reg} + (DECIMATION_BITS + 1)'(1);
    assign emit      = (phase_reg == '0);

    // ------------------------------------------------------------------------
    // Configuration writes. Writing the tap count also empties the history
    // and restarts the decimation phase.
    // ------------------------------------------------------------------------
    always_comb
    begin
        tap_count_next  = tap_count_reg;
        decimation_next = decimation_reg;
        clear_hist      = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAP_COUNT:
                begin
                    tap_count_next = cfg_data[TAP_COUNT_BITS-1:0];
                    clear_hist     = 1'b1;
                end
                REG_DECIMATION:
                begin
                    decimation_next = cfg_data[DECIMATION_BITS-1:0];
                end
                default:
                begin
                    tap_count_next = tap_count_reg;
                end
            endcase
        end
    end

    // The phase steps on every sample and wraps once it reaches the
    // decimation, which also covers a decimation lowered below the phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (clear_hist)
        begin
            phase_next = '0;
        end
        else if (sample_xfer)
        begin
            if (phase_inc >= {1'b0, dec_eff})
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_inc[DECIMATION_BITS-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer && emit)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (cnt_reg == TAP_IDX_BITS'(MAX_TAPS - 1))
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs. During the rotation the cell at the head holds
    // tap position cnt_reg, and a full turn brings every cell back home.
    // ------------------------------------------------------------------------
    always_comb
    begin
        rotate          = 1'b0;
        out_load        = 1'b0;
        mac_ctl.start   = 1'b0;
        mac_ctl.prod_en = 1'b0;
        cnt_next        = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next      = '0;
                mac_ctl.start = sample_xfer && emit;
            end
            ST_ROT:
            begin
                rotate          = 1'b1;
                cnt_next        = cnt_reg + TAP_IDX_BITS'(1);
                mac_ctl.prod_en = (CNT_BITS'(cnt_reg) < ntaps);
            end
            ST_TAIL:
            begin
                cnt_next = '0;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Ring of tap cells. A shift moves the history one position toward the
    // old end with the new sample entering cell 0; a rotate moves history
    // and coefficients one position toward cell 0, wrapping at the end.
    // ------------------------------------------------------------------------
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        cell_ctl_t cell_ctl;
        cplx_t     shift_src;

        assign cell_ctl.clear   = clear_hist;
        assign cell_ctl.shift   = sample_xfer;
        assign cell_ctl.rotate  = rotate;
        assign cell_ctl.coef_we = tap_xfer && (int'(item.tap_index) == k);

        if (k == 0)
        begin : g_head
            assign shift_src = new_sample;
        end
        else
        begin : g_body
            assign shift_src = hist[k-1];
        end

        dfir_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .tap_val     (tap_val),
            .shift_in    (shift_src),
            .rot_hist_in (hist[(k + 1) % MAX_TAPS]),
            .rot_coef_in (coef[(k + 1) % MAX_TAPS]),
            .hist        (hist[k]),
            .coef        (coef[k])
        );
    end

    // Multiply-accumulate at the head of the ring.
    dfir_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .h     (coef[0]),
        .x     (hist[0]),
        .res   (mac_res)
    );

    // ------------------------------------------------------------------------
    // Output register. A finished result waits here so that the next items
    // can be taken while the downstream side stalls.
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= mac_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg  <= TAP_COUNT_BITS'(1);
            decimation_reg <= DECIMATION_BITS'(1);
            phase_reg      <= '0;
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tap_count_reg  <= tap_count_next;
            decimation_reg <= decimation_next;
            phase_reg      <= phase_next;
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_re    = out_reg.re;
    assign result.out_im    = out_reg.im;
    assign result.saturated = out_reg.sat;

endmodule

/* tb/sv/decimating_complex_fir_core_tb.sv */
// ----------------------------------------------------------------------------
// decimating_complex_fir_core_tb
// Self-checking bench for the decimating complex FIR core. It sends tap
// writes and complex samples over the item stream and reprograms tap_count
// and decimation between phases. A built-in fixed-point filter predicts each
// kept output, and the bench compares every output transfer field by field.
// ----------------------------------------------------------------------------
module decimating_complex_fir_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfir_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Items that make no output leave the core idle, so a short pause is
    // enough before a register write once the last output has arrived.
    localparam int SETTLE_CYCLES = 8;
    // Long enough for one kept sample to pass through the ring, with margin.
    localparam int TAIL_CYCLES   = MAX_TAPS + 16;
    localparam int RANDOM_PHASES = 8;
    localparam int STREAM_ITEMS  = 42;

    localparam logic signed [SAMPLE_BITS-1:0] Q_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Q_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic                     cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    dfir_in_if  item_bus ();
    dfir_out_if result_bus ();

    decimating_complex_fir_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter predictor. It mirrors the tap store, the delay line of past
    // samples (index 0 holds the newest), the decimation phase and both
    // registers as the bench believes the core holds them.
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] taps_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] taps_im [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] line_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] line_im [MAX_TAPS];
    int                            decim_phase;
    int                            taps_in_use;
    int                            decim_ratio;

    // Outputs predicted but not yet seen, oldest first.
    result_t pending_outputs [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int cycle_count;

    function automatic void clear_line();
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            line_re[k] = '0;
            line_im[k] = '0;
        end
        decim_phase = 0;
    endfunction

    function automatic void fir_reset();
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            taps_re[k] = '0;
            taps_im[k] = '0;
        end
        clear_line();
        taps_in_use = 1;
        decim_ratio = 1;
    endfunction

    // Rounds an exact Q2.30-scaled sum half up to Q1.15 and clips it to the
    // sample range, flagging any clipping.
    function automatic logic signed [SAMPLE_BITS-1:0] round_clip(input longint acc,
                                                               inout bit clipped);
        longint lim_hi;
        longint lim_lo;
        longint r;
        lim_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lim_lo = -(longint'(1) <<< (SAMPLE_BITS - 1));
        r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > lim_hi)
        begin
            r = lim_hi;
            clipped = 1'b1;
        end
        else if (r < lim_lo)
        begin
            r = lim_lo;
            clipped = 1'b1;
        end
        return SAMPLE_BITS'(r);
    endfunction

    // Updates the predictor for one accepted item and queues the output that
    // the item causes, if any.
    function automatic void fir_accept(input logic                          item_kind,
                                       input logic [TAP_INDEX_BITS-1:0]     idx,
                                       input logic signed [SAMPLE_BITS-1:0] t_re,
                                       input logic signed [SAMPLE_BITS-1:0] t_im,
                                       input logic signed [SAMPLE_BITS-1:0] s_re,
                                       input logic signed [SAMPLE_BITS-1:0] s_im);
        int      dec;
        int      n;
        bit      keep;
        bit      clipped;
        longint  acc_re;
        longint  acc_im;
        result_t y;
        if (item_kind == KIND_TAP)
        begin
            // The index field is only 8 bits, so it always lands in the store.
            taps_re[idx] = t_re;
            taps_im[idx] = t_im;
            return;
        end
        for (int k = MAX_TAPS - 1; k > 0; k--)
        begin
            line_re[k] = line_re[k-1];
            line_im[k] = line_im[k-1];
        end
        line_re[0] = s_re;
        line_im[0] = s_im;

        // A decimation of zero behaves as one. A phase left at or above a
        // lowered decimation wraps to zero on this sample.
        dec = (decim_ratio == 0) ? 1 : decim_ratio;
        keep = (decim_phase == 0);
        decim_phase = (decim_phase + 1 >= dec) ? 0 : decim_phase + 1;
        if (!keep)
            return;

        // A tap count of zero uses one tap; one above the store uses all taps.
        n = (taps_in_use == 0) ? 1 : taps_in_use;
        if (n > MAX_TAPS)
            n = MAX_TAPS;

        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < n; k++)
        begin
            acc_re += longint'(taps_re[k]) * longint'(line_re[k])
                    - longint'(taps_im[k]) * longint'(line_im[k]);
            acc_im += longint'(taps_re[k]) * longint'(line_im[k])
                    + longint'(taps_im[k]) * longint'(line_re[k]);
        end
        clipped = 1'b0;
        y.re  = round_clip(acc_re, clipped);
        y.im  = round_clip(acc_im, clipped);
        y.sat = clipped;
        pending_outputs.push_back(y);
    endfunction

    // Mixes full-scale values, the two extremes and small values so that
    // outputs are not clipped all the time.
    function automatic logic signed [SAMPLE_BITS-1:0] rand_q15();
        case ($urandom_range(0, 7)) inside
            0:       return Q_MIN;
            1:       return Q_MAX;
            [2:3]:   return SAMPLE_BITS'($urandom);
            default: return SAMPLE_BITS'($urandom_range(0, 4095)) - SAMPLE_BITS'(2048);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stalls on ready, and the check of every output
    // transfer against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_outputs
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("output transfer with no prediction pending: re %0d im %0d sat %0b",
                       result_bus.out_re, result_bus.out_im, result_bus.saturated);
                mismatch_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result_bus.out_re !== want.re)
                begin
                    $error("out_re: expected %0d, got %0d", want.re, result_bus.out_re);
                    mismatch_count++;
                end
                if (result_bus.out_im !== want.im)
                begin
                    $error("out_im: expected %0d, got %0d", want.im, result_bus.out_im);
                    mismatch_count++;
                end
                if (result_bus.saturated !== want.sat)
                begin
                    $error("saturated: expected %0b, got %0b", want.sat,
                           result_bus.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("decimating_complex_fir_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side. Every task below is entered and left just after a rising
    // edge, and drives the core with nonblocking assignments. A valid that
    // stays high from one item to the next is never lowered in between, so
    // each time step sees at most one assignment to it.
    // ------------------------------------------------------------------------
    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic push_item(input logic                          item_kind,
                             input logic [TAP_INDEX_BITS-1:0]     idx,
                             input logic signed [SAMPLE_BITS-1:0] t_re,
                             input logic signed [SAMPLE_BITS-1:0] t_im,
                             input logic signed [SAMPLE_BITS-1:0] s_re,
                             input logic signed [SAMPLE_BITS-1:0] s_im);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.kind      <= item_kind;
        item_bus.tap_index <= idx;
        item_bus.tap_re    <= t_re;
        item_bus.tap_im    <= t_im;
        item_bus.sample_re <= s_re;
        item_bus.sample_im <= s_im;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        fir_accept(item_kind, idx, t_re, t_im, s_re, s_im);
    endtask

    // The fields that an item kind does not use carry random values.
    task automatic send_tap(input logic [TAP_INDEX_BITS-1:0]     idx,
                            input logic signed [SAMPLE_BITS-1:0] t_re,
                            input logic signed [SAMPLE_BITS-1:0] t_im);
        push_item(KIND_TAP, idx, t_re, t_im, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s_re,
                               input logic signed [SAMPLE_BITS-1:0] s_im);
        push_item(KIND_SAMPLE, TAP_INDEX_BITS'($urandom), SAMPLE_BITS'($urandom),
                  SAMPLE_BITS'($urandom), s_re, s_im);
    endtask

    // Holds the stream until every predicted output has been seen, then lets
    // any trailing no-output item finish inside the core.
    task automatic wait_for_outputs();
        item_bus.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the core idle.
    task automatic write_reg(input logic reg_index, input logic [CFG_DATA_BITS-1:0] value);
        wait_for_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (reg_index == REG_TAP_COUNT)
        begin
            taps_in_use = int'(value);
            clear_line();
        end
        else
            decim_ratio = int'(value[DECIMATION_BITS-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the taps are zero, one tap is used and every sample is kept.
    task automatic test_reset_state();
        send_sample(Q_MAX, Q_MIN);
    endtask

    // Extreme operands with a single tap: the complex product of two most
    // negative values clips the imaginary part, and half an LSB rounds up in
    // both directions.
    task automatic test_extremes();
        send_tap(0, Q_MIN, Q_MIN);
        send_sample(Q_MIN, Q_MIN);
        send_sample(Q_MAX, Q_MAX);
        send_tap(0, 1, 0);
        send_sample(16384, -16384);
        send_sample(-16384, 16384);
        send_tap(0, Q_MAX, 0);
        send_sample(Q_MAX, Q_MIN);
    endtask

    // A tap count of zero uses one tap; the largest 9-bit count uses the whole
    // store, so tap 1 comes into play from the second sample on.
    task automatic test_tap_count_limits();
        write_reg(REG_TAP_COUNT, 0);
        send_sample(100, -200);
        write_reg(REG_TAP_COUNT, {TAP_COUNT_BITS{1'b1}});
        send_tap(1, Q_MAX, Q_MIN);
        send_sample(1000, 1000);
        send_sample(-5, 7);
    endtask

    // Decimation of zero keeps every sample, the largest decimation keeps one
    // in 255, a tap write leaves the phase alone, and lowering the decimation
    // below the running phase makes the phase wrap on the next sample.
    task automatic test_decimation();
        write_reg(REG_DECIMATION, 0);
        send_sample(Q_MAX, 1);
        send_sample(-1, Q_MIN);
        write_reg(REG_DECIMATION, CFG_DATA_BITS'({DECIMATION_BITS{1'b1}}));
        write_reg(REG_TAP_COUNT, 2);
        send_sample(300, -300);
        send_sample(-7, 9);
        send_sample(Q_MIN, Q_MAX);
        write_reg(REG_DECIMATION, 4);
        write_reg(REG_TAP_COUNT, 2);
        send_sample(1234, -4321);
        send_tap(0, -20000, 12000);
        send_sample(555, 666);
        send_sample(-777, 888);
        write_reg(REG_DECIMATION, 2);
        send_sample(42, -42);
        send_sample(-1000, 2000);
    endtask

    // One random phase: fresh register settings, a run of tap writes from
    // index 0 up, then mostly samples with a few stray tap writes. The phase
    // number picks the idling mode, cycling through none, sender only,
    // receiver only and both.
    task automatic test_random_stream(input int phase_no);
        int                       tap_total;
        int                       decim;
        int                       prefix;
        logic [CFG_DATA_BITS-1:0] decim_word;
        case (phase_no % 4)
            0:       set_idling(0, 0);
            1:       set_idling(60, 0);
            2:       set_idling(0, 60);
            default: set_idling(21, 21);
        endcase

        case ($urandom_range(0, 9))
            0:       tap_total = MAX_TAPS;
            1:       tap_total = $urandom_range(MAX_TAPS + 1, (1 << TAP_COUNT_BITS) - 1);
            2:       tap_total = 0;
            default: tap_total = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0:       decim = 0;
            1:       decim = $urandom_range(4, 16);
            default: decim = $urandom_range(1, 3);
        endcase
        // The register is 8 bits wide; the ninth data bit is set at random
        // and must have no effect.
        decim_word = {1'($urandom_range(0, 1)), DECIMATION_BITS'(decim)};

        // Sometimes only the decimation is rewritten, so history and phase
        // carry over from the previous phase.
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_DECIMATION, decim_word);
        else if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_TAP_COUNT, CFG_DATA_BITS'(tap_total));
            write_reg(REG_DECIMATION, decim_word);
        end
        else
        begin
            write_reg(REG_DECIMATION, decim_word);
            write_reg(REG_TAP_COUNT, CFG_DATA_BITS'(tap_total));
        end

        prefix = (tap_total < 1) ? 1 : ((tap_total > 16) ? 16 : tap_total);
        for (int k = 0; k < prefix; k++)
            send_tap(TAP_INDEX_BITS'(k), rand_q15(), rand_q15());

        for (int i = 0; i < STREAM_ITEMS; i++)
        begin
            // Once in the run the sender holds off until the core has
            // delivered everything outstanding.
            if (phase_no == 1 && i == STREAM_ITEMS / 2)
                wait_for_outputs();
            if ($urandom_range(0, 99) < 15)
                send_tap(TAP_INDEX_BITS'($urandom_range(0, MAX_TAPS - 1)), rand_q15(),
                         rand_q15());
            else
                send_sample(rand_q15(), rand_q15());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count = 0;
        set_idling(0, 0);
        fir_reset();

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_TAP_COUNT;
        cfg_data            <= '0;
        item_bus.valid      <= 1'b0;
        item_bus.kind       <= KIND_SAMPLE;
        item_bus.tap_index  <= '0;
        item_bus.tap_re     <= '0;
        item_bus.tap_im     <= '0;
        item_bus.sample_re  <= '0;
        item_bus.sample_im  <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_extremes();
        test_tap_count_limits();
        test_decimation();
        for (int p = 0; p < RANDOM_PHASES; p++)
            test_random_stream(p);

        // Drain, then watch a little longer for outputs nobody asked for.
        wait_for_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("decimating_complex_fir_core: match");
        else
            $display("decimating_complex_fir_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dfir_pkg.sv
hdl/dfir_if.sv
hdl/dfir_cell.sv
hdl/dfir_mac.sv
hdl/decimating_complex_fir_core.sv
tb/sv/decimating_complex_fir_core_tb.sv
